### src/grlm_pkg.sv
// ----------------------------------------------------------------------------
// grlm_pkg: shared types and constants of the grouped resource lock manager
// Operation codes, configuration register indexes and the command/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package grlm_pkg;

    localparam int OP_W       = 3;
    localparam int RES_W      = 4;
    localparam int SET_W      = 16;
    localparam int GRP_W      = 4;
    localparam int MAP_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [OP_W-1:0] {
        OP_TAKE    = 3'd0,
        OP_RELEASE = 3'd1,
        OP_COMMIT  = 3'd2,
        OP_ABORT   = 3'd3,
        OP_QUERY   = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESENT = 2'd0,
        CFG_GROUPED = 2'd1,
        CFG_MAP     = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REL,
        ST_CLOSE,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic use_idx;    // select resource by sweep index, else by request
        logic idx_clr;
        logic idx_inc;
        logic do_take;
        logic do_free;
        logic only_pend;  // free only when the selected resource is pending
        logic do_close;
        logic clr_pend;
        logic st_load;
        logic st_val;
        logic load_rsp;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic busy;
        logic idx_last;
    } t_dp_sts;

endpackage

### src/grlm_req_if.sv
// ----------------------------------------------------------------------------
// grlm_req_if: request channel
// Valid/ready channel carrying one lock operation and its resource index.
// ----------------------------------------------------------------------------
interface grlm_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [3:0] resource;

    modport source (output valid, output operation, output resource, input ready);
    modport sink   (input valid, input operation, input resource, output ready);
endinterface

### src/grlm_rsp_if.sv
// ----------------------------------------------------------------------------
// grlm_rsp_if: response channel
// Valid/ready channel carrying status and the pending and free sets.
// ----------------------------------------------------------------------------
interface grlm_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [15:0] pending_set;
    logic [15:0] free_set;

    modport source (output valid, output status, output pending_set, output free_set,
                    input ready);
    modport sink   (input valid, input status, input pending_set, input free_set,
                    output ready);
endinterface

### src/grlm_cfg_if.sv
// ----------------------------------------------------------------------------
// grlm_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface grlm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/grlm_dp.sv
// ----------------------------------------------------------------------------
// grlm_dp: lock table datapath
// Configuration registers, free/open/pending bits, sweep index and the
// response register. One resource is updated per cycle as commanded.
// ----------------------------------------------------------------------------
module grlm_dp import grlm_pkg::*; #(
    parameter int RESOURCES = 16,
    parameter int GROUPS    = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [RES_W-1:0]      i_resource,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_rsp_status,
    output logic [SET_W-1:0]      o_rsp_pending,
    output logic [SET_W-1:0]      o_rsp_free
);

    localparam int IW = $clog2(RESOURCES);

    logic [SET_W-1:0]     r_present;
    logic [SET_W-1:0]     r_grouped;
    logic [MAP_W-1:0]     r_map;
    logic [RESOURCES-1:0] r_free, n_free;
    logic [GROUPS-1:0]    r_open, n_open;
    logic [RESOURCES-1:0] r_pend, n_pend;
    logic [IW-1:0]        r_idx, n_idx;
    logic                 r_status;
    logic [SET_W-1:0]     r_rsp_pending;
    logic [SET_W-1:0]     r_rsp_free;

    logic [RESOURCES-1:0] sel_oh, gvalid, members, free_after;
    logic [GRP_W-1:0]     sel_g;
    logic [GROUPS-1:0]    g_oh;
    logic                 sel_known, sel_gvalid, sel_pend, sel_free, sel_open;
    logic                 grp_idle;

    // resource and group decode of the selected resource
    always_comb begin
        sel_g = '0;
        for (int r = 0; r < RESOURCES; r++) begin
            sel_oh[r] = i_cmd.use_idx ? (r_idx == IW'(r)) : (i_resource == RES_W'(r));
            gvalid[r] = r_present[r] && r_grouped[r]
                        && (int'(r_map[GRP_W*r +: GRP_W]) < GROUPS);
            if (sel_oh[r]) begin
                sel_g = sel_g | r_map[GRP_W*r +: GRP_W];
            end
        end
        sel_known  = |(sel_oh & r_present[RESOURCES-1:0]);
        sel_gvalid = |(sel_oh & gvalid);
        sel_pend   = |(sel_oh & r_pend);
        sel_free   = |(sel_oh & r_free);
        for (int j = 0; j < GROUPS; j++) begin
            g_oh[j] = sel_gvalid && (int'(sel_g) == j);
        end
        sel_open = |(g_oh & r_open);
        for (int r = 0; r < RESOURCES; r++) begin
            members[r] = gvalid[r] && (r_map[GRP_W*r +: GRP_W] == sel_g);
        end
        free_after = r_free | sel_oh;
        grp_idle   = (members & ~free_after) == '0;
    end

    assign o_sts.busy     = sel_known && (!sel_free || (sel_gvalid && !sel_open));
    assign o_sts.idx_last = (r_idx == IW'(RESOURCES - 1));

    always_comb begin
        n_free = r_free;
        n_open = r_open;
        n_pend = r_pend;
        if (i_cmd.do_take && sel_known) begin
            n_free = r_free & ~sel_oh;
            n_pend = r_pend | sel_oh;
        end
        if (i_cmd.do_free && sel_known && (!i_cmd.only_pend || sel_pend)) begin
            n_free = free_after;
            // group reopens once its last taken member is freed
            if (sel_gvalid && grp_idle) begin
                n_open = r_open | g_oh;
            end
        end
        if (i_cmd.do_close && sel_pend && sel_gvalid) begin
            n_open = r_open & ~g_oh;
        end
        if (i_cmd.clr_pend) begin
            n_pend = '0;
        end
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + IW'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_grouped <= '0;
            r_map     <= '0;
            r_free    <= '1;
            r_open    <= '1;
            r_pend    <= '0;
            r_idx     <= '0;
        end else begin
            r_free <= n_free;
            r_open <= n_open;
            r_pend <= n_pend;
            r_idx  <= n_idx;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PRESENT: r_present <= i_cfg_data[SET_W-1:0];
                    CFG_GROUPED: r_grouped <= i_cfg_data[SET_W-1:0];
                    CFG_MAP:     r_map     <= i_cfg_data[MAP_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.st_load) begin
            r_status <= i_cmd.st_val;
        end
        if (i_cmd.load_rsp) begin
            r_rsp_pending <= SET_W'(r_pend);
            r_rsp_free    <= SET_W'(r_free);
        end
    end

    logic r_rsp_status;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rsp) begin
            r_rsp_status <= r_status;
        end
    end

    assign o_rsp_status  = r_rsp_status;
    assign o_rsp_pending = r_rsp_pending;
    assign o_rsp_free    = r_rsp_free;

endmodule

### src/grlm_ctrl.sv
// ----------------------------------------------------------------------------
// grlm_ctrl: lock manager controller
// Decodes a request, runs the rollback and commit sweeps and hands the
// response to the output register.
// ----------------------------------------------------------------------------
module grlm_ctrl import grlm_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  logic [OP_W-1:0] i_op,
    output logic            o_req_ready,
    input  logic            i_rsp_ready,
    output logic            o_rsp_valid,
    input  t_dp_sts         i_sts,
    output t_dp_cmd         o_cmd
);

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.st_load = 1'b1;
                    unique case (i_op)
                        OP_TAKE: begin
                            if (i_sts.busy) begin
                                // rejected: roll back the transaction
                                o_cmd.st_val  = 1'b1;
                                o_cmd.idx_clr = 1'b1;
                                n_state       = ST_REL;
                            end else begin
                                o_cmd.do_take = 1'b1;
                                n_state       = ST_DONE;
                            end
                        end
                        OP_RELEASE: begin
                            o_cmd.do_free = 1'b1;
                            n_state       = ST_DONE;
                        end
                        OP_COMMIT: begin
                            o_cmd.idx_clr = 1'b1;
                            n_state       = ST_CLOSE;
                        end
                        OP_ABORT: begin
                            o_cmd.idx_clr = 1'b1;
                            n_state       = ST_REL;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_REL: begin
                o_cmd.use_idx   = 1'b1;
                o_cmd.do_free   = 1'b1;
                o_cmd.only_pend = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.clr_pend = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_CLOSE: begin
                o_cmd.use_idx  = 1'b1;
                o_cmd.do_close = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.clr_pend = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    o_cmd.load_rsp = 1'b1;
                    n_rsp_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;

endmodule

### src/grouped_resource_lock_manager.sv
// ----------------------------------------------------------------------------
// grouped_resource_lock_manager: lock table with grouped resources
// Top level: request, response and configuration channels around the
// controller and the lock table datapath.
// ----------------------------------------------------------------------------
// Each request is one of take, release, commit, abort or query and yields
// exactly one response carrying status (1 = take rejected as busy, the open
// transaction rolled back) and the pending and free sets after the request.
// Take, release and query go from accept straight to the done state, which
// loads the response register; commit, abort and a rejected take first sweep
// the lock table one resource per cycle. The next request is accepted in the
// cycle after the response is loaded, while that response may still wait on
// the output register. Configuration writes are always accepted and must only
// be issued while the block is idle; writes to an index beyond the register
// list are ignored.
// ----------------------------------------------------------------------------
module grouped_resource_lock_manager import grlm_pkg::*; #(
    parameter int RESOURCES = 16,
    parameter int GROUPS    = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    grlm_req_if.sink       i_req,
    grlm_rsp_if.source     o_rsp,
    grlm_cfg_if.sink       i_cfg
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    req_ready;
    logic    rsp_valid;

    // configuration registers take a write in any cycle
    assign i_cfg.ready = 1'b1;

    grlm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_op        (i_req.operation),
        .o_req_ready (req_ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (rsp_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    grlm_dp #(
        .RESOURCES (RESOURCES),
        .GROUPS    (GROUPS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_resource    (i_req.resource),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_rsp_status  (o_rsp.status),
        .o_rsp_pending (o_rsp.pending_set),
        .o_rsp_free    (o_rsp.free_set)
    );

    assign i_req.ready = req_ready;
    assign o_rsp.valid = rsp_valid;

`ifndef SYNTH
    // one request at a time: ready drops after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request accepted while another is in progress");

    // a rollback always leaves an empty pending set
    a_busy_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status |-> o_rsp.pending_set == '0)
        else $error("busy response with pending resources");

    // no response straight out of reset
    a_reset_no_rsp: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_rsp.valid)
        else $error("response valid after reset");
`endif

endmodule
